@@ sv/vsdf_pkg.sv @@
// Package for the voxel signed distance field block.
// Holds the sequencer states, operation and register codes, defaults and the
// step weight function. No dependencies.
package vsdf_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OBS,
        S_RD_FREE,
        S_RD_MUL,
        S_RD_OUT,
        S_INIT_RD,
        S_INIT_WR_OBS,
        S_INIT_WR_FREE,
        S_RLX_OWN,
        S_RLX_NB,
        S_RLX_WAIT,
        S_RLX_WR,
        S_DONE
    } t_state;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [2:0] REG_SIZE_X    = 3'd0;
    localparam logic [2:0] REG_SIZE_Y    = 3'd1;
    localparam logic [2:0] REG_SIZE_Z    = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    localparam int DEF_MAX_X     = 32;
    localparam int DEF_MAX_Y     = 32;
    localparam int DEF_MAX_Z     = 32;
    localparam int DEF_FRAC_BITS = 8;

    localparam logic [5:0]  RST_SIZE      = 6'd32;
    localparam logic [15:0] RST_CELL_SIZE = 16'd3277;
    localparam logic [8:0]  RST_THRESHOLD = 9'd192;

    localparam logic [15:0] UNREACHED = 16'hFFFF;
    localparam logic [15:0] DIST_CAP  = 16'hFFFE;

    // round(sqrt(n) * 2^frac), evaluated at elaboration.
    function automatic int step_weight(input int n, input int frac);
        longint v;
        longint r;
        v = longint'(n) << (2 * frac);
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        if ((2 * r + 1) * (2 * r + 1) <= 4 * v) r++;
        return int'(r);
    endfunction

endpackage

@@ sv/voxel_signed_distance_field.sv @@
// A cell write is accepted every cycle while idle. A read inside the grid runs
// S_RD_OBS, S_RD_FREE, S_RD_MUL and S_RD_OUT; one outside goes straight to S_RD_OUT.
// S_RD_OUT raises the result once the output is free; no new item is taken till then.
// A compute seeds both maps cell by cell, then relaxes each cell per sweep (own read,
// 27 offset reads, a wait and a write-back); sweeps repeat until one changes nothing,
// for each map. Reset: control and configuration go to defaults.
module voxel_signed_distance_field #(
    parameter int MAX_X     = vsdf_pkg::DEF_MAX_X,
    parameter int MAX_Y     = vsdf_pkg::DEF_MAX_Y,
    parameter int MAX_Z     = vsdf_pkg::DEF_MAX_Z,
    parameter int FRAC_BITS = vsdf_pkg::DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x[4:0], cell_y[9:5], cell_z[14:10], occupancy[23:15]
    input  logic [23:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // signed_distance[24:0], no_obstacles[25], no_free_cells[26]
    output logic [31:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int CW = 10;
    localparam int OW = XW + YW + ZW;
    localparam int AW = OW + 1;
    localparam logic [15:0] W1 = 16'(vsdf_pkg::step_weight(1, FRAC_BITS));
    localparam logic [15:0] W2 = 16'(vsdf_pkg::step_weight(2, FRAC_BITS));
    localparam logic [15:0] W3 = 16'(vsdf_pkg::step_weight(3, FRAC_BITS));

    vsdf_pkg::t_state r_state, n_state;

    logic [5:0]  r_size_x, r_size_y, r_size_z;
    logic [15:0] r_cell_size;
    logic [8:0]  r_threshold;

    logic [15:0] r_dist_mem [2**AW];
    logic        r_obs_mem  [2**OW];
    logic [15:0] r_rdata;
    logic        r_obit;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [1:0]    r_dx, r_dy, r_dz;
    logic          r_map, r_bwd, r_changed, r_any_obs, r_any_free;
    logic          r_pend_own, r_pend_nb;
    logic [1:0]    r_pend_steps;
    logic [15:0]   r_best, r_own;
    logic signed [33:0] r_prod;

    logic        r_out_valid, r_out_kind, r_out_no_obs, r_out_no_free;
    logic [24:0] r_out_sd;

    logic [5:0] w_nx, w_ny, w_nz;
    logic [1:0] w_op;
    logic [CW-1:0] w_cx, w_cy, w_cz, w_ax, w_ay, w_az;
    logic w_in_acc, w_inside, w_out_free, w_last, w_nb_ok, w_nb_last;
    logic [1:0] w_steps;
    logic [XW-1:0] w_x_nx;
    logic [YW-1:0] w_y_nx;
    logic [ZW-1:0] w_z_nx;
    logic [XW-1:0] w_x_st;
    logic [YW-1:0] w_y_st;
    logic [ZW-1:0] w_z_st;
    logic [OW-1:0] w_cell, w_ncell, w_in_cell;
    logic          w_dre, w_dwe, w_owe, w_ore;
    logic [AW-1:0] w_dra, w_dwa;
    logic [15:0]   w_dwd, w_wt;
    logic [16:0]   w_sum;
    logic [15:0]   w_cand;
    logic signed [33:0] w_shift;
    logic [24:0]   w_sd;

    function automatic logic [5:0] used_size(input logic [5:0] v, input int mx);
        logic [5:0] r;
        if (v == 6'd0) r = 6'd1;
        else if ({3'b000, v} > 9'(mx)) r = 6'(mx);
        else r = v;
        return r;
    endfunction

    assign w_nx = used_size(r_size_x, MAX_X);
    assign w_ny = used_size(r_size_y, MAX_Y);
    assign w_nz = used_size(r_size_z, MAX_Z);

    assign s_axis_tready = (r_state == vsdf_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_cx          = CW'(s_axis_tdata[4:0]);
    assign w_cy          = CW'(s_axis_tdata[9:5]);
    assign w_cz          = CW'(s_axis_tdata[14:10]);
    assign w_inside      = (w_cx < CW'(w_nx)) && (w_cy < CW'(w_ny)) && (w_cz < CW'(w_nz));
    assign w_in_cell     = {w_cx[XW-1:0], w_cy[YW-1:0], w_cz[ZW-1:0]};
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_cell = {r_x, r_y, r_z};

    // Neighbor coordinates; a step below zero wraps high and fails the bound.
    assign w_ax = CW'(r_x) + CW'(r_dx) - CW'(1);
    assign w_ay = CW'(r_y) + CW'(r_dy) - CW'(1);
    assign w_az = CW'(r_z) + CW'(r_dz) - CW'(1);
    assign w_ncell = {w_ax[XW-1:0], w_ay[YW-1:0], w_az[ZW-1:0]};
    assign w_steps = 2'(r_dx != 2'd1) + 2'(r_dy != 2'd1) + 2'(r_dz != 2'd1);
    assign w_nb_ok = (w_steps != 2'd0) && (w_ax < CW'(w_nx)) && (w_ay < CW'(w_ny))
                     && (w_az < CW'(w_nz));
    assign w_nb_last = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);

    // Walk to the next cell of the sweep, forward or backward.
    always_comb begin
        w_x_nx = r_x;
        w_y_nx = r_y;
        w_z_nx = r_z;
        if (!r_bwd) begin
            w_last = (CW'(r_x) == CW'(w_nx) - CW'(1)) && (CW'(r_y) == CW'(w_ny) - CW'(1))
                     && (CW'(r_z) == CW'(w_nz) - CW'(1));
            if (CW'(r_z) == CW'(w_nz) - CW'(1)) begin
                w_z_nx = '0;
                if (CW'(r_y) == CW'(w_ny) - CW'(1)) begin
                    w_y_nx = '0;
                    w_x_nx = r_x + XW'(1);
                end else begin
                    w_y_nx = r_y + YW'(1);
                end
            end else begin
                w_z_nx = r_z + ZW'(1);
            end
        end else begin
            w_last = (r_x == '0) && (r_y == '0) && (r_z == '0);
            if (r_z == '0) begin
                w_z_nx = ZW'(w_nz - 6'd1);
                if (r_y == '0) begin
                    w_y_nx = YW'(w_ny - 6'd1);
                    w_x_nx = r_x - XW'(1);
                end else begin
                    w_y_nx = r_y - YW'(1);
                end
            end else begin
                w_z_nx = r_z - ZW'(1);
            end
        end
    end

    always_comb begin
        unique case (r_pend_steps)
            2'd1:    w_wt = W1;
            2'd2:    w_wt = W2;
            default: w_wt = W3;
        endcase
        w_sum  = {1'b0, r_rdata} + {1'b0, w_wt};
        w_cand = (w_sum > {1'b0, vsdf_pkg::DIST_CAP}) ? vsdf_pkg::DIST_CAP : w_sum[15:0];
    end

    // Floor shift then clamp to the 25-bit signed range.
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        if (w_shift > 34'sd16777215) w_sd = 25'h0FFFFFF;
        else if (w_shift < -34'sd16777216) w_sd = 25'h1000000;
        else w_sd = w_shift[24:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vsdf_pkg::S_IDLE: begin
                if (w_in_acc && w_op == vsdf_pkg::OP_COMPUTE) n_state = vsdf_pkg::S_INIT_RD;
                else if (w_in_acc && w_op == vsdf_pkg::OP_READ)
                    n_state = w_inside ? vsdf_pkg::S_RD_OBS : vsdf_pkg::S_RD_OUT;
            end
            vsdf_pkg::S_RD_OBS:       n_state = vsdf_pkg::S_RD_FREE;
            vsdf_pkg::S_RD_FREE:      n_state = vsdf_pkg::S_RD_MUL;
            vsdf_pkg::S_RD_MUL:       n_state = vsdf_pkg::S_RD_OUT;
            vsdf_pkg::S_RD_OUT:       if (w_out_free) n_state = vsdf_pkg::S_IDLE;
            vsdf_pkg::S_INIT_RD:      n_state = vsdf_pkg::S_INIT_WR_OBS;
            vsdf_pkg::S_INIT_WR_OBS:  n_state = vsdf_pkg::S_INIT_WR_FREE;
            vsdf_pkg::S_INIT_WR_FREE:
                n_state = w_last ? vsdf_pkg::S_RLX_OWN : vsdf_pkg::S_INIT_RD;
            vsdf_pkg::S_RLX_OWN:      n_state = vsdf_pkg::S_RLX_NB;
            vsdf_pkg::S_RLX_NB:       if (w_nb_last) n_state = vsdf_pkg::S_RLX_WAIT;
            vsdf_pkg::S_RLX_WAIT:     n_state = vsdf_pkg::S_RLX_WR;
            vsdf_pkg::S_RLX_WR: begin
                if (w_last && !r_changed && r_best == r_own && r_map)
                    n_state = vsdf_pkg::S_DONE;
                else
                    n_state = vsdf_pkg::S_RLX_OWN;
            end
            vsdf_pkg::S_DONE:         if (w_out_free) n_state = vsdf_pkg::S_IDLE;
            default:                  n_state = vsdf_pkg::S_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        w_dre = 1'b0;
        w_dra = {1'b0, w_cell};
        w_dwe = 1'b0;
        w_dwa = {r_map, w_cell};
        w_dwd = r_best;
        w_owe = 1'b0;
        w_ore = 1'b0;
        unique case (r_state)
            vsdf_pkg::S_IDLE:
                w_owe = w_in_acc && (w_op == vsdf_pkg::OP_WRITE) && w_inside;
            vsdf_pkg::S_RD_OBS: begin
                w_dre = 1'b1;
                w_dra = {1'b0, w_cell};
            end
            vsdf_pkg::S_RD_FREE: begin
                w_dre = 1'b1;
                w_dra = {1'b1, w_cell};
            end
            vsdf_pkg::S_INIT_RD:      w_ore = 1'b1;
            vsdf_pkg::S_INIT_WR_OBS: begin
                w_dwe = 1'b1;
                w_dwa = {1'b0, w_cell};
                w_dwd = r_obit ? 16'd0 : vsdf_pkg::UNREACHED;
            end
            vsdf_pkg::S_INIT_WR_FREE: begin
                w_dwe = 1'b1;
                w_dwa = {1'b1, w_cell};
                w_dwd = r_obit ? vsdf_pkg::UNREACHED : 16'd0;
            end
            vsdf_pkg::S_RLX_OWN: begin
                w_dre = 1'b1;
                w_dra = {r_map, w_cell};
            end
            vsdf_pkg::S_RLX_NB: begin
                w_dre = 1'b1;
                w_dra = {r_map, w_ncell};
            end
            vsdf_pkg::S_RLX_WR: begin
                w_dwe = (r_best != r_own);
                w_dwa = {r_map, w_cell};
                w_dwd = r_best;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) r_dist_mem[w_dwa] <= w_dwd;
        if (w_dre) r_rdata <= r_dist_mem[w_dra];
        if (w_owe) r_obs_mem[w_in_cell] <= (s_axis_tdata[23:15] > r_threshold);
        if (w_ore) r_obit <= r_obs_mem[w_cell];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x    <= vsdf_pkg::RST_SIZE;
            r_size_y    <= vsdf_pkg::RST_SIZE;
            r_size_z    <= vsdf_pkg::RST_SIZE;
            r_cell_size <= vsdf_pkg::RST_CELL_SIZE;
            r_threshold <= vsdf_pkg::RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vsdf_pkg::REG_SIZE_X:    r_size_x    <= i_cfg_data[5:0];
                vsdf_pkg::REG_SIZE_Y:    r_size_y    <= i_cfg_data[5:0];
                vsdf_pkg::REG_SIZE_Z:    r_size_z    <= i_cfg_data[5:0];
                vsdf_pkg::REG_CELL_SIZE: r_cell_size <= i_cfg_data;
                vsdf_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_x_st = r_bwd ? '0 : XW'(w_nx - 6'd1);
    assign w_y_st = r_bwd ? '0 : YW'(w_ny - 6'd1);
    assign w_z_st = r_bwd ? '0 : ZW'(w_nz - 6'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsdf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_pend_own  <= 1'b0;
            r_pend_nb   <= 1'b0;
            r_map       <= 1'b0;
            r_bwd       <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tready && !(w_out_free && (r_state == vsdf_pkg::S_RD_OUT
                                                 || r_state == vsdf_pkg::S_DONE)))
                r_out_valid <= 1'b0;
            r_pend_own <= (r_state == vsdf_pkg::S_RLX_OWN);
            r_pend_nb  <= (r_state == vsdf_pkg::S_RLX_NB) && w_nb_ok;
            unique case (r_state)
                vsdf_pkg::S_IDLE: begin
                    if (w_in_acc && w_op == vsdf_pkg::OP_COMPUTE) begin
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                        r_map <= 1'b0;
                        r_bwd <= 1'b0;
                        r_changed <= 1'b0;
                        r_any_obs <= 1'b0;
                        r_any_free <= 1'b0;
                    end else if (w_in_acc) begin
                        r_x <= w_cx[XW-1:0];
                        r_y <= w_cy[YW-1:0];
                        r_z <= w_cz[ZW-1:0];
                        r_prod <= '0;
                    end
                end
                vsdf_pkg::S_RD_FREE: r_own <= r_rdata;
                vsdf_pkg::S_RD_MUL:
                    r_prod <= ($signed({1'b0, r_own}) - $signed({1'b0, r_rdata}))
                              * $signed({1'b0, r_cell_size});
                vsdf_pkg::S_RD_OUT, vsdf_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_kind    <= (r_state == vsdf_pkg::S_RD_OUT);
                        r_out_sd      <= (r_state == vsdf_pkg::S_RD_OUT) ? w_sd : '0;
                        r_out_no_obs  <= (r_state == vsdf_pkg::S_DONE) && !r_any_obs;
                        r_out_no_free <= (r_state == vsdf_pkg::S_DONE) && !r_any_free;
                    end
                end
                vsdf_pkg::S_INIT_WR_OBS: begin
                    if (r_obit) r_any_obs <= 1'b1;
                    else r_any_free <= 1'b1;
                end
                vsdf_pkg::S_INIT_WR_FREE: begin
                    if (w_last) begin
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                    end else begin
                        r_x <= w_x_nx;
                        r_y <= w_y_nx;
                        r_z <= w_z_nx;
                    end
                end
                vsdf_pkg::S_RLX_OWN: begin
                    r_dx <= 2'd0;
                    r_dy <= 2'd0;
                    r_dz <= 2'd0;
                end
                vsdf_pkg::S_RLX_NB: begin
                    r_pend_steps <= w_steps;
                    if (r_dz != 2'd2) begin
                        r_dz <= r_dz + 2'd1;
                    end else begin
                        r_dz <= 2'd0;
                        if (r_dy != 2'd2) begin
                            r_dy <= r_dy + 2'd1;
                        end else begin
                            r_dy <= 2'd0;
                            r_dx <= r_dx + 2'd1;
                        end
                    end
                end
                vsdf_pkg::S_RLX_WR: begin
                    if (!w_last) begin
                        r_x <= w_x_nx;
                        r_y <= w_y_nx;
                        r_z <= w_z_nx;
                        if (r_best != r_own) r_changed <= 1'b1;
                    end else if (r_changed || r_best != r_own) begin
                        // Sweep changed something: run the opposite direction.
                        r_bwd <= !r_bwd;
                        r_changed <= 1'b0;
                        r_x <= w_x_st;
                        r_y <= w_y_st;
                        r_z <= w_z_st;
                    end else begin
                        r_map <= 1'b1;
                        r_bwd <= 1'b0;
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                    end
                end
                default: ;
            endcase
            if (r_pend_own) begin
                r_own  <= r_rdata;
                r_best <= r_rdata;
            end else if (r_pend_nb && r_rdata != vsdf_pkg::UNREACHED && w_cand < r_best) begin
                r_best <= w_cand;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'd0, r_out_no_free, r_out_no_obs, r_out_sd};

    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_own && r_pend_nb))
        else $error("own and neighbor reads pending together");

    a_best_le_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vsdf_pkg::S_RLX_WR) |-> (r_best <= r_own))
        else $error("relaxed distance above stored distance");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_op == vsdf_pkg::OP_COMPUTE) |=> !s_axis_tready)
        else $error("input accepted during compute");

    a_nb_follows_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vsdf_pkg::S_RLX_OWN) |=> (r_state == vsdf_pkg::S_RLX_NB && r_pend_own))
        else $error("own read not followed by neighbor walk");

endmodule
